/* sv/rvdec_pkg.sv */
// RV32I decoder package: operation codes, opcode constants, result type and
// the single-pass decode function. No dependencies.
package rvdec_pkg;

	localparam int OpW = 6;
	localparam int RegW = 5;
	localparam int XLen = 32;

	// operation numbers
	localparam logic [OpW-1:0] OP_ADD   = 6'd0;
	localparam logic [OpW-1:0] OP_SUB   = 6'd1;
	localparam logic [OpW-1:0] OP_SLL   = 6'd2;
	localparam logic [OpW-1:0] OP_SLT   = 6'd3;
	localparam logic [OpW-1:0] OP_SLTU  = 6'd4;
	localparam logic [OpW-1:0] OP_XOR   = 6'd5;
	localparam logic [OpW-1:0] OP_SRL   = 6'd6;
	localparam logic [OpW-1:0] OP_SRA   = 6'd7;
	localparam logic [OpW-1:0] OP_OR    = 6'd8;
	localparam logic [OpW-1:0] OP_AND   = 6'd9;
	localparam logic [OpW-1:0] OP_ADDI  = 6'd10;
	localparam logic [OpW-1:0] OP_SLTI  = 6'd11;
	localparam logic [OpW-1:0] OP_SLTIU = 6'd12;
	localparam logic [OpW-1:0] OP_XORI  = 6'd13;
	localparam logic [OpW-1:0] OP_ORI   = 6'd14;
	localparam logic [OpW-1:0] OP_ANDI  = 6'd15;
	localparam logic [OpW-1:0] OP_JALR  = 6'd16;
	localparam logic [OpW-1:0] OP_LB    = 6'd17;
	localparam logic [OpW-1:0] OP_LH    = 6'd18;
	localparam logic [OpW-1:0] OP_LW    = 6'd19;
	localparam logic [OpW-1:0] OP_LBU   = 6'd20;
	localparam logic [OpW-1:0] OP_LHU   = 6'd21;
	localparam logic [OpW-1:0] OP_SLLI  = 6'd22;
	localparam logic [OpW-1:0] OP_SRLI  = 6'd23;
	localparam logic [OpW-1:0] OP_SRAI  = 6'd24;
	localparam logic [OpW-1:0] OP_BNE   = 6'd25;
	localparam logic [OpW-1:0] OP_BEQ   = 6'd26;
	localparam logic [OpW-1:0] OP_BLT   = 6'd27;
	localparam logic [OpW-1:0] OP_BGE   = 6'd28;
	localparam logic [OpW-1:0] OP_BLTU  = 6'd29;
	localparam logic [OpW-1:0] OP_BGEU  = 6'd30;
	localparam logic [OpW-1:0] OP_SB    = 6'd31;
	localparam logic [OpW-1:0] OP_SH    = 6'd32;
	localparam logic [OpW-1:0] OP_SW    = 6'd33;
	localparam logic [OpW-1:0] OP_JAL   = 6'd34;
	localparam logic [OpW-1:0] OP_LUI   = 6'd35;
	localparam logic [OpW-1:0] OP_AUIPC = 6'd36;
	localparam logic [OpW-1:0] OP_ECALL = 6'd37;
	localparam logic [OpW-1:0] OP_NONE  = 6'd38;

	// major opcodes
	localparam logic [6:0] OPC_REG    = 7'b0110011;
	localparam logic [6:0] OPC_IMM    = 7'b0010011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

	localparam logic [6:0] F7_BASE = 7'b0000000;
	localparam logic [6:0] F7_ALT  = 7'b0100000;

	localparam logic [XLen-1:0] ECALL_WORD = 32'd115;

	typedef struct packed {
		logic [OpW-1:0]         operation;
		logic [RegW-1:0]        dest_reg;
		logic [RegW-1:0]        src_reg_a;
		logic [RegW-1:0]        src_reg_b;
		logic signed [XLen-1:0] immediate;
		logic [XLen-1:0]        target;
		logic                   halt;
	} dec_t;

	function automatic dec_t decode(input logic [XLen-1:0] instr, input logic [XLen-1:0] pc);
		logic [XLen-1:0] w;
		logic [6:0]      opc;
		logic [2:0]      f3;
		logic [6:0]      f7;
		logic [XLen-1:0] imm_i, imm_s, imm_b, imm_j, imm_u;
		dec_t            r;
		// an all-zero word decodes as ECALL
		w = (instr == '0) ? ECALL_WORD : instr;
		opc = w[6:0];
		f3 = w[14:12];
		f7 = w[31:25];
		imm_i = {{20{w[31]}}, w[31:20]};
		imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
		imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
		imm_u = {w[31:12], 12'b0};

		r.operation = OP_NONE;
		r.dest_reg = w[11:7];
		r.src_reg_a = w[19:15];
		r.src_reg_b = w[24:20];
		r.immediate = '0;
		r.target = '0;
		r.halt = 1'b0;

		case (opc)
			OPC_REG: begin
				case (f3)
					3'd0: begin
						if (f7 == F7_BASE) r.operation = OP_ADD;
						else if (f7 == F7_ALT) r.operation = OP_SUB;
					end
					3'd1: r.operation = OP_SLL;
					3'd2: r.operation = OP_SLT;
					3'd3: r.operation = OP_SLTU;
					3'd4: r.operation = OP_XOR;
					3'd5: begin
						if (f7 == F7_BASE) r.operation = OP_SRL;
						else if (f7 == F7_ALT) r.operation = OP_SRA;
					end
					3'd6: r.operation = OP_OR;
					default: r.operation = OP_AND;
				endcase
			end
			OPC_IMM: begin
				case (f3)
					3'd0: r.operation = OP_ADDI;
					3'd1: if (f7 == F7_BASE) r.operation = OP_SLLI;
					3'd2: r.operation = OP_SLTI;
					3'd3: r.operation = OP_SLTIU;
					3'd4: r.operation = OP_XORI;
					3'd5: begin
						if (f7 == F7_BASE) r.operation = OP_SRLI;
						else if (f7 == F7_ALT) r.operation = OP_SRAI;
					end
					3'd6: r.operation = OP_ORI;
					default: r.operation = OP_ANDI;
				endcase
				if (r.operation != OP_NONE) r.immediate = imm_i;
			end
			OPC_JALR: begin
				if (f3 == 3'd0) begin
					r.operation = OP_JALR;
					r.immediate = imm_i;
				end
			end
			OPC_LOAD: begin
				case (f3)
					3'd0: r.operation = OP_LB;
					3'd1: r.operation = OP_LH;
					3'd2: r.operation = OP_LW;
					3'd4: r.operation = OP_LBU;
					3'd5: r.operation = OP_LHU;
					default: r.operation = OP_NONE;
				endcase
				if (r.operation != OP_NONE) r.immediate = imm_i;
			end
			OPC_BRANCH: begin
				case (f3)
					3'd0: r.operation = OP_BEQ;
					3'd1: r.operation = OP_BNE;
					3'd4: r.operation = OP_BLT;
					3'd5: r.operation = OP_BGE;
					3'd6: r.operation = OP_BLTU;
					3'd7: r.operation = OP_BGEU;
					default: r.operation = OP_NONE;
				endcase
				if (r.operation != OP_NONE) begin
					r.immediate = imm_b;
					r.target = pc + imm_b;
				end
			end
			OPC_STORE: begin
				case (f3)
					3'd0: r.operation = OP_SB;
					3'd1: r.operation = OP_SH;
					3'd2: r.operation = OP_SW;
					default: r.operation = OP_NONE;
				endcase
				if (r.operation != OP_NONE) r.immediate = imm_s;
			end
			OPC_JAL: begin
				r.operation = OP_JAL;
				r.immediate = imm_j;
				r.target = pc + imm_j;
			end
			OPC_LUI: begin
				r.operation = OP_LUI;
				r.immediate = imm_u;
			end
			OPC_AUIPC: begin
				r.operation = OP_AUIPC;
				r.immediate = imm_u;
			end
			OPC_SYSTEM: begin
				// any system encoding is taken as ECALL
				r.operation = OP_ECALL;
				r.halt = 1'b1;
			end
			default: r.operation = OP_NONE;
		endcase
		return r;
	endfunction

endpackage

/* sv/rv32i_instruction_decoder.sv */
// RV32I instruction decoder top level: input register, decode logic, result register.
// Depends on rvdec_pkg (decode function, result type, operation codes).
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata: instruction, pc
// m_*      out  m_tvalid/m_tready  m_tdata: operation .. target; m_tuser: halt
//
// Two register stages; an input transfer loads the input register, and the decoded
// result is registered when the output stage can advance. One instruction per cycle
// sustained without output stalls; the 32-bit pc-plus-offset add sets the path.
// Reset clears both stage valid bits only.
// A stalled output holds its result; the input stage keeps taking words until it is full.
module rv32i_instruction_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] instruction, [63:32] pc
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // [5:0] operation, [10:6] dest_reg, [15:11] src_reg_a,
	                               // [20:16] src_reg_b, [52:21] immediate, [84:53] target,
	                               // [87:85] zero
	output logic        m_tuser    // [0] halt
);
	import rvdec_pkg::*;

	logic            valid_s1;
	logic [XLen-1:0] instr_s1;
	logic [XLen-1:0] pc_s1;
	logic            valid_s2;
	dec_t            res_s2;
	dec_t            dec;
	logic            adv_s2;

	assign adv_s2 = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			instr_s1 <= s_tdata[31:0];
			pc_s1 <= s_tdata[63:32];
		end
		if (adv_s2 && valid_s1) res_s2 <= dec;
	end

	assign dec = decode(instr_s1, pc_s1);

	assign m_tvalid = valid_s2;
	assign m_tdata = {3'b000, res_s2.target, res_s2.immediate, res_s2.src_reg_b,
		res_s2.src_reg_a, res_s2.dest_reg, res_s2.operation};
	assign m_tuser = res_s2.halt;

`ifndef SYNTHESIS
	a_halt_is_ecall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> res_s2.operation == OP_ECALL)
		else $error("halt without ECALL");

	a_target_only_jumps: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.target != '0 |->
			(res_s2.operation >= OP_BNE && res_s2.operation <= OP_BGEU) ||
			res_s2.operation == OP_JAL)
		else $error("target set for non-branch operation");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_tready |-> !s_tready)
		else $error("input taken while both stages are blocked");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("decoded word lost between stages");
`endif

endmodule
